// ===== rtl/core/max_pool_2d_with_index_unit_defines.svh =====
// Assertion macros shared by the max pooling unit.
`ifndef MAX_POOL_2D_WITH_INDEX_UNIT_DEFINES_SVH
`define MAX_POOL_2D_WITH_INDEX_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MPWI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define MPWI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MPWI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MPWI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/mpwi_pkg.sv =====
// Shared constants and types of the max pooling unit.
package mpwi_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_KERNEL = 8;
    localparam int STORE_ROWS = 32;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SLOT_W = $clog2(STORE_ROWS);
    localparam int TAP_W  = $clog2(MAX_KERNEL);
    localparam int ADDR_W = SLOT_W + COL_W;
    localparam int DEPTH  = STORE_ROWS * MAX_WIDTH;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 20;
    localparam int DIM_W    = 11;
    localparam int KER_W    = 4;
    localparam int STR_W    = 4;
    localparam int DIL_W    = 3;
    localparam int SPAN_W   = KER_W + DIL_W;
    localparam int DIV_W    = 10;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KROWS  = 3'd2;
    localparam logic [2:0] REG_KCOLS  = 3'd3;
    localparam logic [2:0] REG_SROWS  = 3'd4;
    localparam logic [2:0] REG_SCOLS  = 3'd5;
    localparam logic [2:0] REG_DROWS  = 3'd6;
    localparam logic [2:0] REG_DCOLS  = 3'd7;

    // Effective geometry after the zero and oversize rules.
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [KER_W-1:0] kr;
        logic [KER_W-1:0] kc;
        logic [STR_W-1:0] sr;
        logic [STR_W-1:0] sc;
        logic [DIL_W-1:0] dr;
        logic [DIL_W-1:0] dc;
    } geom_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic scan_init;
        logic scan_step;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic cond;
        logic div_done;
        logic hit;
        logic scan_last;
        logic out_free;
    } sts_t;
endpackage

// ===== rtl/core/mpwi_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mpwi_div
    import mpwi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [STR_W-1:0]  divisor,
    output logic [DIV_W-1:0]  quot,
    output logic [STR_W-1:0]  rem,
    output logic              busy
);
    logic [DIV_W-1:0]     dvd_reg;
    logic [STR_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [STR_W:0]       shifted;
    logic                 ge;

    // Bring down the next dividend bit and try a subtraction.
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DIV_W-1]};
        ge      = shifted >= {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Quotient bits shift into the dividend register from the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? STR_W'(shifted - {1'b0, divisor}) : shifted[STR_W-1:0];
        end
    end

    assign quot = dvd_reg;
    assign rem  = rem_reg;
    assign busy = busy_reg;
endmodule

// ===== rtl/core/mpwi_datapath.sv =====
// Position counters, line store, phase dividers, tap scan and result register.
module mpwi_datapath
    import mpwi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  geom_t                      geom,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [SAMPLE_W-1:0] window_max,
    output logic [INDEX_W-1:0]         max_index,
    output logic                       last_in_plane,
    output logic                       out_valid,
    input  logic                       out_stall
);
    logic [SAMPLE_W-1:0] store_mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] cur_c;
    logic [ROW_W-1:0] cur_r;
    logic [DIM_W-1:0] row_adv;
    logic [DIM_W-1:0] row_inc, col_inc;
    logic [SPAN_W-1:0] span_r, span_c;
    logic cond;

    logic [ROW_W-1:0] oh_reg;
    logic [COL_W-1:0] ow_reg;
    logic [DIV_W-1:0] hlim_reg, wlim_reg;

    logic [DIV_W-1:0] q_oh, q_ow, q_h, q_w;
    logic [STR_W-1:0] r_oh, r_ow, r_h, r_w;
    logic b_oh, b_ow, b_h, b_w;

    logic [TAP_W-1:0] ti_reg, tj_reg;
    logic [ROW_W-1:0] tr_reg, tr_d_reg;
    logic [COL_W-1:0] tc_reg, tc_d_reg;
    logic first_reg, first_d_reg, rd_valid_reg;
    logic last_i, last_j;

    logic signed [SAMPLE_W-1:0] best_reg;
    logic [INDEX_W-1:0] best_idx_reg;
    logic [INDEX_W-1:0] tap_idx;
    logic take;

    logic out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_max_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic out_last_reg;

    // Position of this sample, wrapping first for a geometry change mid-plane.
    always_comb
    begin
        row_adv = DIM_W'(row_count_reg) + 1'b1;
        if (DIM_W'(col_count_reg) >= geom.w)
        begin
            cur_c = '0;
            cur_r = (row_adv >= geom.h) ? '0 : row_adv[ROW_W-1:0];
        end
        else
        begin
            cur_c = col_count_reg;
            cur_r = (DIM_W'(row_count_reg) >= geom.h) ? '0 : row_count_reg;
        end
        span_r = SPAN_W'((geom.kr - 1'b1) * geom.dr);
        span_c = SPAN_W'((geom.kc - 1'b1) * geom.dc);
        cond   = (DIM_W'(cur_r) >= DIM_W'(span_r)) && (DIM_W'(cur_c) >= DIM_W'(span_c));
    end

    // Position after this sample.
    always_comb
    begin
        col_inc = DIM_W'(cur_c) + 1'b1;
        row_inc = DIM_W'(cur_r) + 1'b1;
        if (col_inc >= geom.w)
        begin
            col_count_next = '0;
            row_count_next = (row_inc >= geom.h) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_count_next = col_inc[COL_W-1:0];
            row_count_next = cur_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Window origin and last-origin bounds for the dividers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            oh_reg   <= ROW_W'(DIM_W'(cur_r) - DIM_W'(span_r));
            ow_reg   <= COL_W'(DIM_W'(cur_c) - DIM_W'(span_c));
            hlim_reg <= DIV_W'(geom.h - 1'b1 - DIM_W'(span_r));
            wlim_reg <= DIV_W'(geom.w - 1'b1 - DIM_W'(span_c));
        end
    end

    mpwi_div u_div_oh (.clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(DIV_W'(oh_reg)), .divisor(geom.sr), .quot(q_oh), .rem(r_oh), .busy(b_oh));
    mpwi_div u_div_ow (.clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(DIV_W'(ow_reg)), .divisor(geom.sc), .quot(q_ow), .rem(r_ow), .busy(b_ow));
    mpwi_div u_div_h (.clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(hlim_reg), .divisor(geom.sr), .quot(q_h), .rem(r_h), .busy(b_h));
    mpwi_div u_div_w (.clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(wlim_reg), .divisor(geom.sc), .quot(q_w), .rem(r_w), .busy(b_w));

    // Tap walk: top row first, left to right.
    assign last_i = ti_reg == TAP_W'(geom.kr - 1'b1);
    assign last_j = tj_reg == TAP_W'(geom.kc - 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            ti_reg    <= '0;
            tj_reg    <= '0;
            tr_reg    <= oh_reg;
            tc_reg    <= ow_reg;
            first_reg <= 1'b1;
        end
        else if (cmd.scan_step)
        begin
            first_reg <= 1'b0;
            if (last_j)
            begin
                tj_reg <= '0;
                tc_reg <= ow_reg;
                ti_reg <= ti_reg + 1'b1;
                tr_reg <= tr_reg + ROW_W'(geom.dr);
            end
            else
            begin
                tj_reg <= tj_reg + 1'b1;
                tc_reg <= tc_reg + COL_W'(geom.dc);
            end
        end
    end

    // Line store: one write per accepted beat, one read per scan cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            store_mem[{cur_r[SLOT_W-1:0], cur_c}] <= sample;
        end
        if (cmd.scan_step)
        begin
            rdata_reg <= store_mem[{tr_reg[SLOT_W-1:0], tc_reg}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        tr_d_reg    <= tr_reg;
        tc_d_reg    <= tc_reg;
        first_d_reg <= first_reg;
    end

    // Running maximum; strictly greater keeps the earliest tap on ties.
    assign tap_idx = INDEX_W'(tr_d_reg) * INDEX_W'(geom.w) + INDEX_W'(tc_d_reg);
    assign take    = rd_valid_reg && (first_d_reg || ($signed(rdata_reg) > best_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg     <= $signed(rdata_reg);
            best_idx_reg <= tap_idx;
        end
    end

    // Result register toward the output channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_max_reg  <= best_reg;
            out_idx_reg  <= best_idx_reg;
            out_last_reg <= (q_oh == q_h) && (q_ow == q_w);
        end
    end

    always_comb
    begin
        sts.cond      = cond;
        sts.div_done  = !(b_oh || b_ow || b_h || b_w);
        sts.hit       = (r_oh == '0) && (r_ow == '0);
        sts.scan_last = last_i && last_j;
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign window_max    = out_max_reg;
    assign max_index     = out_idx_reg;
    assign last_in_plane = out_last_reg;
    assign out_valid     = out_valid_reg;

    // Remainders of the bound divisions only feed nothing but keep the units uniform.
    logic unused_rem;
    assign unused_rem = ^{r_h, r_w};
endmodule

// ===== rtl/core/mpwi_ctrl.sv =====
// Sequencer for one beat: phase division, tap scan and result hand-off.
`include "max_pool_2d_with_index_unit_defines.svh"
module mpwi_ctrl
    import mpwi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    state_t state_reg, state_next;

    // Commands follow from the state and the status of the datapath.
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.accept     = (state_reg == ST_IDLE) && in_valid;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.cond)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.scan_init = sts.hit;
                    state_next    = sts.hit ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // The result register is only loaded when it is free.
    `MPWI_ASSERT_SAME(a_push_free, clk, rst_n, cmd.push, sts.out_free)
    // A scan ends with a drain state, which passes straight to the push state for the hand-off.
    `MPWI_ASSERT_NEXT(a_drain_push, clk, rst_n, state_reg == ST_DRAIN, state_reg == ST_PUSH)
    // An accepted beat either finishes at once or starts the dividers.
    `MPWI_ASSERT_NEXT(a_accept_next, clk, rst_n, cmd.accept,
        (state_reg == ST_IDLE) || (state_reg == ST_DIV_START))
endmodule

// ===== rtl/core/max_pool_2d_with_index_unit.sv =====
// A beat that completes no window origin ends on acceptance; otherwise the phase
// dividers run and, on a hit, the taps are scanned and a result is pushed.
// One beat is in flight at a time: the phase division and the one-tap-per-cycle
// read port of the line store set the rate.
// Reset clears counters, control and configuration (all registers read 1);
// line store contents are undefined until written.
module max_pool_2d_with_index_unit
    import mpwi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] window_max,
    output logic [INDEX_W-1:0]         max_index,
    output logic                       last_in_plane
);
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [KER_W-1:0] krows_reg, kcols_reg;
    logic [STR_W-1:0] srows_reg, scols_reg;
    logic [DIL_W-1:0] drows_reg, dcols_reg;
    logic [2:0]       reg_idx;
    logic             wr_en;
    geom_t            geom;
    cmd_t             cmd;
    sts_t             sts;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            krows_reg  <= KER_W'(1);
            kcols_reg  <= KER_W'(1);
            srows_reg  <= STR_W'(1);
            scols_reg  <= STR_W'(1);
            drows_reg  <= DIL_W'(1);
            dcols_reg  <= DIL_W'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_KROWS:  krows_reg  <= pwdata[KER_W-1:0];
                REG_KCOLS:  kcols_reg  <= pwdata[KER_W-1:0];
                REG_SROWS:  srows_reg  <= pwdata[STR_W-1:0];
                REG_SCOLS:  scols_reg  <= pwdata[STR_W-1:0];
                REG_DROWS:  drows_reg  <= pwdata[DIL_W-1:0];
                REG_DCOLS:  dcols_reg  <= pwdata[DIL_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_KROWS:  prdata = 32'(krows_reg);
            REG_KCOLS:  prdata = 32'(kcols_reg);
            REG_SROWS:  prdata = 32'(srows_reg);
            REG_SCOLS:  prdata = 32'(scols_reg);
            REG_DROWS:  prdata = 32'(drows_reg);
            REG_DCOLS:  prdata = 32'(dcols_reg);
            default:    prdata = '0;
        endcase
    end

    // Zero fields act as 1; plane size and kernel saturate at their maxima.
    always_comb
    begin
        geom.w  = (width_reg == '0) ? DIM_W'(1) :
                  (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
        geom.h  = (height_reg == '0) ? DIM_W'(1) :
                  (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
        geom.kr = (krows_reg == '0) ? KER_W'(1) :
                  (krows_reg > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : krows_reg;
        geom.kc = (kcols_reg == '0) ? KER_W'(1) :
                  (kcols_reg > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kcols_reg;
        geom.sr = (srows_reg == '0) ? STR_W'(1) : srows_reg;
        geom.sc = (scols_reg == '0) ? STR_W'(1) : scols_reg;
        geom.dr = (drows_reg == '0) ? DIL_W'(1) : drows_reg;
        geom.dc = (dcols_reg == '0) ? DIL_W'(1) : dcols_reg;
    end

    mpwi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mpwi_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .geom          (geom),
        .cmd           (cmd),
        .sts           (sts),
        .sample        (sample),
        .window_max    (window_max),
        .max_index     (max_index),
        .last_in_plane (last_in_plane),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );
endmodule
